### design/mcld_pkg.sv
// shared types and constants for the multi-connection length deframer
// no dependencies; used by the interfaces and every module of the block
package mcld_pkg;

  localparam int CONNS   = 16;
  localparam int CONN_W  = 4;
  localparam int CIW     = (CONNS > 1) ? $clog2(CONNS) : 1;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // classified item kind handed from front to back
  typedef enum logic [2:0] {
    K_IGNORE,
    K_NOCONN,
    K_OPEN,
    K_CLOSE,
    K_DATA
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADLEN  = 3'd1,
    ST_ALREADY = 3'd2,
    ST_NOTOPEN = 3'd3,
    ST_ABORT   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t             kind;
    logic [CONN_W-1:0] conn;
    logic [7:0]        data_byte;
  } item_t;

  typedef struct packed {
    logic [CONN_W-1:0] conn;
    logic              byte_valid;
    logic [7:0]        out_byte;
    logic              first_of_packet;
    logic              last_of_packet;
    status_t           status;
  } result_t;

  // queue write side
  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  // queue read side
  typedef struct packed {
    logic  avail;
    item_t item;
  } q_rd_t;

endpackage

### design/mcld_if.sv
// channel interfaces of the length deframer: input beats and result beats
// depends on mcld_pkg for field widths
interface mcld_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic [mcld_pkg::CONN_W-1:0]   conn;
  logic [7:0]                    data_byte;

  modport source (output valid, cmd, conn, data_byte, input ready);
  modport sink   (input valid, cmd, conn, data_byte, output ready);
endinterface

interface mcld_out_if;
  logic                          valid;
  logic                          ready;
  logic [mcld_pkg::CONN_W-1:0]   out_conn;
  logic                          byte_valid;
  logic [7:0]                    out_byte;
  logic                          first_of_packet;
  logic                          last_of_packet;
  logic [2:0]                    status;

  modport source (output valid, out_conn, byte_valid, out_byte, first_of_packet,
                  last_of_packet, status, input ready);
  modport sink   (input valid, out_conn, byte_valid, out_byte, first_of_packet,
                  last_of_packet, status, output ready);
endinterface

### design/mcld_front.sv
// front end: accepts input beats and classifies them into item kinds
// depends on mcld_pkg and mcld_in_if
module mcld_front (
  mcld_in_if.sink          in_if,
  input  logic             q_full,
  output mcld_pkg::q_wr_t  q_wr
);

  logic in_range;

  assign in_if.ready = !q_full;
  assign in_range    = int'(in_if.conn) < mcld_pkg::CONNS;

  always_comb begin
    q_wr.push           = in_if.valid && !q_full;
    q_wr.item.conn      = in_if.conn;
    q_wr.item.data_byte = in_if.data_byte;
    unique case (mcld_pkg::cmd_t'(in_if.cmd))
      mcld_pkg::CMD_NONE:  q_wr.item.kind = mcld_pkg::K_IGNORE;
      mcld_pkg::CMD_OPEN:  q_wr.item.kind = in_range ? mcld_pkg::K_OPEN  : mcld_pkg::K_NOCONN;
      mcld_pkg::CMD_CLOSE: q_wr.item.kind = in_range ? mcld_pkg::K_CLOSE : mcld_pkg::K_NOCONN;
      mcld_pkg::CMD_DATA:  q_wr.item.kind = in_range ? mcld_pkg::K_DATA  : mcld_pkg::K_NOCONN;
      default:             q_wr.item.kind = mcld_pkg::K_IGNORE;
    endcase
  end

endmodule

### design/mcld_queue.sv
// short queue of classified items between front and back
// depends on mcld_pkg
module mcld_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  mcld_pkg::q_wr_t  q_wr,
  input  logic             pop,
  output logic             full,
  output mcld_pkg::q_rd_t  q_rd
);

  localparam int AW = mcld_pkg::Q_AW;

  mcld_pkg::item_t slot_r [mcld_pkg::Q_DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     count_r, count_nxt;
  logic            do_pop;

  assign full       = count_r == (AW+1)'(mcld_pkg::Q_DEPTH);
  assign q_rd.avail = count_r != '0;
  assign q_rd.item  = slot_r[rd_ptr_r];
  assign do_pop     = pop && q_rd.avail;

  always_comb begin
    wr_ptr_nxt = q_wr.push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    case ({q_wr.push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      slot_r[wr_ptr_r] <= q_wr.item;
    end
  end

endmodule

### design/mcld_back.sv
// back end: per-connection state update and registered result beat
// depends on mcld_pkg and mcld_out_if
module mcld_back (
  input  logic             clk,
  input  logic             rst_n,
  input  mcld_pkg::q_rd_t  q_rd,
  output logic             pop,
  mcld_out_if.source       out_if
);

  localparam int CIW = mcld_pkg::CIW;

  logic                  open_r  [mcld_pkg::CONNS];
  mcld_pkg::phase_t      phase_r [mcld_pkg::CONNS];
  logic [7:0]            high_r  [mcld_pkg::CONNS];
  logic [15:0]           owed_r  [mcld_pkg::CONNS];

  mcld_pkg::result_t     res_r, res_nxt;
  logic                  out_valid_r;

  logic [CIW-1:0]        idx;
  logic                  cur_open;
  mcld_pkg::phase_t      cur_phase;
  logic [7:0]            cur_high;
  logic [15:0]           cur_owed;

  logic                  wr_en;
  logic                  open_nxt;
  mcld_pkg::phase_t      phase_nxt;
  logic [7:0]            high_nxt;
  logic [15:0]           owed_nxt;

  logic [15:0]           len;
  logic [15:0]           owed_dec;
  logic [7:0]            b;

  assign pop = q_rd.avail && (!out_valid_r || out_if.ready);

  assign idx       = CIW'(q_rd.item.conn);
  assign cur_open  = open_r[idx];
  assign cur_phase = phase_r[idx];
  assign cur_high  = high_r[idx];
  assign cur_owed  = owed_r[idx];
  assign b         = q_rd.item.data_byte;
  assign len       = {cur_high, b};
  assign owed_dec  = (cur_owed != 16'd0) ? cur_owed - 16'd1 : 16'd0;

  always_comb begin
    res_nxt                 = '0;
    res_nxt.conn            = q_rd.item.conn;
    res_nxt.status          = mcld_pkg::ST_OK;
    wr_en                   = 1'b0;
    open_nxt                = cur_open;
    phase_nxt               = cur_phase;
    high_nxt                = cur_high;
    owed_nxt                = cur_owed;
    unique case (q_rd.item.kind)
      mcld_pkg::K_IGNORE: begin
      end
      mcld_pkg::K_NOCONN: begin
        res_nxt.status = mcld_pkg::ST_NOTOPEN;
      end
      mcld_pkg::K_OPEN: begin
        if (cur_open) begin
          res_nxt.status = mcld_pkg::ST_ALREADY;
        end else begin
          wr_en     = 1'b1;
          open_nxt  = 1'b1;
          phase_nxt = mcld_pkg::PH_HIGH;
          high_nxt  = '0;
          owed_nxt  = '0;
        end
      end
      mcld_pkg::K_CLOSE: begin
        if (!cur_open) begin
          res_nxt.status = mcld_pkg::ST_NOTOPEN;
        end else begin
          if (cur_phase != mcld_pkg::PH_HIGH || cur_owed != 16'd0) begin
            res_nxt.status         = mcld_pkg::ST_ABORT;
            res_nxt.last_of_packet = 1'b1;
          end
          wr_en     = 1'b1;
          open_nxt  = 1'b0;
          phase_nxt = mcld_pkg::PH_HIGH;
          high_nxt  = '0;
          owed_nxt  = '0;
        end
      end
      mcld_pkg::K_DATA: begin
        if (!cur_open) begin
          res_nxt.status = mcld_pkg::ST_NOTOPEN;
        end else begin
          res_nxt.byte_valid = 1'b1;
          res_nxt.out_byte   = b;
          wr_en              = 1'b1;
          case (cur_phase)
            mcld_pkg::PH_LOW: begin
              if (len < 16'd2) begin
                // bad length tears the connection down
                res_nxt.status         = mcld_pkg::ST_BADLEN;
                res_nxt.last_of_packet = 1'b1;
                open_nxt               = 1'b0;
                phase_nxt              = mcld_pkg::PH_HIGH;
                high_nxt               = '0;
                owed_nxt               = '0;
              end else if (len == 16'd2) begin
                res_nxt.last_of_packet = 1'b1;
                phase_nxt              = mcld_pkg::PH_HIGH;
                owed_nxt               = '0;
              end else begin
                owed_nxt  = len - 16'd2;
                phase_nxt = mcld_pkg::PH_BODY;
              end
            end
            mcld_pkg::PH_BODY: begin
              owed_nxt = owed_dec;
              if (owed_dec == 16'd0) begin
                res_nxt.last_of_packet = 1'b1;
                phase_nxt              = mcld_pkg::PH_HIGH;
              end
            end
            default: begin
              res_nxt.first_of_packet = 1'b1;
              high_nxt                = b;
              phase_nxt               = mcld_pkg::PH_LOW;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mcld_pkg::CONNS; i++) begin
        open_r[i]  <= 1'b0;
        phase_r[i] <= mcld_pkg::PH_HIGH;
        high_r[i]  <= '0;
        owed_r[i]  <= '0;
      end
    end else if (pop && wr_en) begin
      open_r[idx]  <= open_nxt;
      phase_r[idx] <= phase_nxt;
      high_r[idx]  <= high_nxt;
      owed_r[idx]  <= owed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.out_conn        = res_r.conn;
  assign out_if.byte_valid      = res_r.byte_valid;
  assign out_if.out_byte        = res_r.out_byte;
  assign out_if.first_of_packet = res_r.first_of_packet;
  assign out_if.last_of_packet  = res_r.last_of_packet;
  assign out_if.status          = res_r.status;

endmodule

### design/multi_connection_length_deframer.sv
// path: an accepted input beat is written into the queue, popped by the back end
// and its result beat registered in res_r; it waits in the queue while results stall
// throughput: one beat per cycle unless the output stalls, set by the per-connection
// state read-modify-write in the back end; a four-entry queue decouples sides
// reset: synchronous active-low rst_n clears queue, result valid flag and all
// per-connection state at once, no clearing pass
module multi_connection_length_deframer (
  input  logic        clk,
  input  logic        rst_n,
  mcld_in_if.sink     in_if,
  mcld_out_if.source  out_if
);

  // front to queue
  mcld_pkg::q_wr_t q_wr;
  logic            q_full;

  // queue to back
  mcld_pkg::q_rd_t q_rd;
  logic            q_pop;

  // classify commands: ignored code, out-of-range connection, open, close, data
  mcld_front u_front (
    .in_if  (in_if),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  // lets the input keep taking beats while a result beat waits downstream
  mcld_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .q_rd  (q_rd)
  );

  // per-connection header tracking, byte tagging and output register
  mcld_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (q_pop),
    .out_if (out_if)
  );

endmodule
